/* src/masked_min_max_normalizer_assert.svh */
// Assertion macros shared by the masked min/max normalizer RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MASKED_MIN_MAX_NORMALIZER_ASSERT_SVH
`define MASKED_MIN_MAX_NORMALIZER_ASSERT_SVH

// Same-cycle implication.
`define MMN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MMN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mmn_pkg.sv */
// Package for the masked min/max normalizer: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmn_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int FRAC_BITS  = 15;
	localparam int MAG_W      = PIXEL_BITS - 1;
	localparam int OUT_W      = FRAC_BITS + 1;
	localparam int S_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;
	localparam int CNT_W      = $clog2(FRAC_BITS + 1);

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [OUT_W-1:0] ONE_Q   = OUT_W'(1) << FRAC_BITS;

	// req_type codes
	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_NORM    = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic             any_valid;
		logic [MAG_W-1:0] min_seen;
		logic [MAG_W-1:0] max_seen;
	} stats_t;

endpackage

`default_nettype wire

/* src/mmn_stats.sv */
// Min/max tracker for the measure pass of the normalizer.
// Depends on mmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmn_stats import mmn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             upd,
	input  wire logic             restart,
	input  wire logic             neg,
	input  wire logic [MAG_W-1:0] mag,
	output stats_t                stats
);

	logic [MAG_W-1:0] min_q, max_q;
	logic             any_q;
	logic [MAG_W-1:0] min_base, max_base;
	logic             any_base;

	// a frame start clears the statistics before this item is folded in
	always_comb begin
		min_base = restart ? MAG_MAX : min_q;
		max_base = restart ? '0 : max_q;
		any_base = restart ? 1'b0 : any_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MAG_MAX;
			max_q <= '0;
			any_q <= 1'b0;
		end else if (upd) begin
			if (neg) begin
				min_q <= min_base;
				max_q <= max_base;
				any_q <= any_base;
			end else begin
				min_q <= (mag < min_base) ? mag : min_base;
				max_q <= (mag > max_base) ? mag : max_base;
				any_q <= 1'b1;
			end
		end
	end

	assign stats.any_valid = any_q;
	assign stats.min_seen  = min_q;
	assign stats.max_seen  = max_q;

endmodule

`default_nettype wire

/* src/mmn_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Computes (num << FRAC_BITS) / den for num < den. Depends on mmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmn_div import mmn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_ctrl_t            ctrl,
	input  wire logic [MAG_W-1:0]     num,
	input  wire logic [MAG_W-1:0]     den,
	output div_stat_t                 stat,
	output logic      [FRAC_BITS-1:0] quot
);

	logic                 run_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MAG_W-1:0]     rem_q;
	logic [MAG_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [MAG_W:0]       trial;
	logic                 fits;
	logic [MAG_W:0]       diff;
	logic                 stepping;

	// remainder stays below den, so doubling fits in MAG_W+1 bits
	always_comb begin
		trial    = {rem_q, 1'b0};
		fits     = trial >= {1'b0, den_q};
		diff     = trial - {1'b0, den_q};
		stepping = run_q && (cnt_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(FRAC_BITS);
		end else if (stepping) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (ctrl.ack) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (stepping) begin
			rem_q  <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], fits};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = run_q && (cnt_q == '0);
	assign quot      = quot_q;

endmodule

`default_nettype wire

/* src/masked_min_max_normalizer.sv */
// Channel  Dir  tdata                 tuser
// s_*      in   pixel[15:0]           req_type[0], frame_start[1]
// m_*      out  norm_value[15:0]      masked[0]
//
// Measure items update the statistics; normalize items that need no division
// load the output directly. A normalize item that divides passes accept, 15
// divider steps (one quotient bit each) and an output load that waits for room.
// s_tready is low while the divider runs and while the output register is
// full and not being taken. Reset clears statistics and control state.
// Top level: sequencer, statistics and divider. Depends on mmn_pkg, mmn_stats,
// mmn_div and masked_min_max_normalizer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_min_max_normalizer_assert.svh"

module masked_min_max_normalizer import mmn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // pixel
	input  wire logic [1:0]           s_tuser,  // req_type, frame_start
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // norm_value
	output logic                      m_tuser   // masked
);

	state_t               state_q, state_nxt;
	stats_t               stats;
	div_ctrl_t            dctrl;
	div_stat_t            dstat;
	logic [FRAC_BITS-1:0] quot;

	logic                 accept;
	logic                 is_norm;
	logic                 neg;
	logic [MAG_W-1:0]     mag;
	logic [MAG_W-1:0]     num;
	logic [MAG_W-1:0]     den;
	logic                 res_zero;
	logic                 res_full;
	logic                 need_div;
	logic                 slot_free;
	logic                 fast_load;
	logic                 div_load;

	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;
	logic                 m_user_q;

	always_comb begin
		neg      = s_tdata[PIXEL_BITS-1];
		mag      = s_tdata[MAG_W-1:0];
		is_norm  = s_tuser[0] == REQ_NORM;
		num      = mag - stats.min_seen;
		den      = stats.max_seen - stats.min_seen;
		// no valid pixel, empty range, or pixel at or below the minimum
		res_zero = !stats.any_valid || (stats.max_seen <= stats.min_seen)
			|| (mag <= stats.min_seen);
		res_full = num >= den;
		need_div = !neg && !res_zero && !res_full;
	end

	assign slot_free = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign fast_load = accept && is_norm && !need_div;
	assign div_load  = (state_q == ST_DIV) && dstat.done && slot_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_norm && need_div) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = 1'b0;
		dctrl.start = 1'b0;
		dctrl.ack   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = slot_free;
				dctrl.start = accept && is_norm && need_div;
			end
			ST_DIV: begin
				dctrl.ack = div_load;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	mmn_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (accept && (s_tuser[0] == REQ_MEASURE)),
		.restart (s_tuser[1]),
		.neg     (neg),
		.mag     (mag),
		.stats   (stats)
	);

	mmn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dctrl),
		.num    (num),
		.den    (den),
		.stat   (dstat),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fast_load || div_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fast_load) begin
			m_user_q <= neg;
			m_data_q <= (neg || !res_zero) ? ONE_Q : '0;
		end else if (div_load) begin
			m_user_q <= 1'b0;
			m_data_q <= OUT_W'(quot);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(m_data_q);
	assign m_tuser  = m_user_q;

	`MMN_ASSERT_IMP(a_no_accept_in_div, state_q == ST_DIV, !s_tready, "item accepted while dividing")
	`MMN_ASSERT_IMP(a_out_range, m_valid_q, m_data_q <= ONE_Q, "normalized value above one")
	`MMN_ASSERT_IMP(a_masked_one, m_valid_q && m_user_q, m_data_q == ONE_Q, "masked item not one")
	`MMN_ASSERT_NXT(a_div_result, div_load, m_valid_q && !m_user_q, "divider result not presented")
	`MMN_ASSERT_IMP(a_div_running, state_q == ST_DIV, dstat.busy, "divider idle in divide state")

endmodule

`default_nettype wire
